// ===== design/hfw_pkg.sv =====
// ----------------------------------------------------------------------------
// hfw_pkg
// Shared types, constants and fixed-point helpers for the wave stepper.
// ----------------------------------------------------------------------------
package hfw_pkg;

	localparam int GRID_X_BITS = 6;
	localparam int GRID_Z_BITS = 6;
	localparam int GRID_X      = 1 << GRID_X_BITS;
	localparam int GRID_Z      = 1 << GRID_Z_BITS;
	localparam int ADDR_W      = GRID_X_BITS + GRID_Z_BITS;
	localparam int DEPTH       = GRID_X * GRID_Z;
	localparam int COL_W       = GRID_X_BITS + 1;

	localparam logic [19:0] GRAVITY_Q16 = 20'd642253;
	localparam logic [16:0] DAMP_Q16    = 17'd65470;

	localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
	localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;

	localparam logic [1:0] MODE_LOAD = 2'd0;
	localparam logic [1:0] MODE_STEP = 2'd1;
	localparam logic [1:0] MODE_READ = 2'd2;

	localparam logic [2:0] CFG_WATER_DEPTH = 3'd0;
	localparam logic [2:0] CFG_SPEED_LEVEL = 3'd1;
	localparam logic [2:0] CFG_INV_AREA    = 3'd2;
	localparam logic [2:0] CFG_ACTIVE_X    = 3'd3;
	localparam logic [2:0] CFG_ACTIVE_Z    = 3'd4;

	localparam logic KIND_READ = 1'b0;
	localparam logic KIND_STEP = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_COEF,
		ST_VEL,
		ST_HGT,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [15:0] water_depth;
		logic [2:0]  speed_level;
		logic [31:0] inverse_cell_area;
		logic [6:0]  active_columns_x;
		logic [6:0]  active_columns_z;
	} cfg_t;

	typedef struct packed {
		logic        result_kind;
		logic [31:0] height;
		logic [31:0] velocity;
		logic        saturated;
	} result_t;

	typedef struct packed {
		logic              h_we;
		logic [ADDR_W-1:0] h_wa;
		logic [31:0]       h_wd;
		logic [ADDR_W-1:0] h_ra;
		logic              v_we;
		logic [ADDR_W-1:0] v_wa;
		logic [31:0]       v_wd;
		logic [ADDR_W-1:0] v_ra;
	} mem_req_t;

	// c2 factor per speed level, unsigned Q3.16; levels above four act as four
	function automatic logic [18:0] speed_factor(input logic [2:0] lvl);
		case (lvl)
			3'd0:    return 19'd262144;
			3'd1:    return 19'd131072;
			3'd2:    return 19'd65536;
			3'd3:    return 19'd52429;
			default: return 19'd32768;
		endcase
	endfunction

	// shift right by 16, half away from zero
	function automatic logic signed [63:0] rnd16(input logic signed [63:0] v);
		logic [63:0] m;
		m = v[63] ? (64'd0 - $unsigned(v)) : $unsigned(v);
		m = (m + 64'd32768) >> 16;
		return v[63] ? $signed(64'd0 - m) : $signed(m);
	endfunction

	function automatic logic ovf32(input logic signed [63:0] v);
		return (v > SAT_MAX) || (v < SAT_MIN);
	endfunction

	function automatic logic [31:0] sat32(input logic signed [63:0] v);
		if (v > SAT_MAX) return 32'h7FFF_FFFF;
		if (v < SAT_MIN) return 32'h8000_0000;
		return v[31:0];
	endfunction

endpackage

// ===== design/height_field_wave_step.sv =====
// ----------------------------------------------------------------------------
// height_field_wave_step
// Height-field water surface stepper over a 64 x 64 grid of columns.
// ----------------------------------------------------------------------------
// One item is worked at a time. A load is written straight from idle, a
// read goes through the read state, then the done state hands over its
// result. A step runs the coefficient setup, then the velocity pass over
// every active cell, then the height pass over every active cell, then
// hands over the result. The velocity pass fetches the center and its
// four neighbors in turn through the single read port of the height RAM.
// Heights and velocities live in two 4096-word RAMs, addressed z*64+x; the
// RAM contents are not cleared, so cells must be loaded before use. The
// result sits in an output register, so a finished result waiting on stall
// does not hold off a following load. Configuration writes are always ready.
module height_field_wave_step (
	input  logic               clk,
	input  logic               arst_n,
	// configuration
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	// command input
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         mode,
	input  logic [5:0]         cell_x,
	input  logic [5:0]         cell_z,
	input  logic signed [31:0] height_value,
	input  logic [15:0]        time_step,
	// results
	output logic               out_valid,
	input  logic               out_stall,
	output logic               result_kind,
	output logic signed [31:0] height_out,
	output logic signed [31:0] velocity_out,
	output logic               saturated
);
	import hfw_pkg::*;

	cfg_t     cfg_q;
	mem_req_t mem_req;
	result_t  res, out_q;
	logic     busy, res_valid, in_take, out_free, out_valid_q;
	logic [31:0] h_rd, v_rd;

	assign cfg_ready = 1'b1;

	// register writes; indexes past the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.water_depth <= 16'd256;
			cfg_q.speed_level <= 3'd2;
			cfg_q.inverse_cell_area <= 32'd65536;
			cfg_q.active_columns_x <= 7'd64;
			cfg_q.active_columns_z <= 7'd64;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_WATER_DEPTH: cfg_q.water_depth <= cfg_data[15:0];
				CFG_SPEED_LEVEL: cfg_q.speed_level <= cfg_data[2:0];
				CFG_INV_AREA:    cfg_q.inverse_cell_area <= cfg_data;
				CFG_ACTIVE_X:    cfg_q.active_columns_x <= cfg_data[6:0];
				CFG_ACTIVE_Z:    cfg_q.active_columns_z <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	assign in_stall = busy;
	assign in_take  = in_valid && !in_stall;

	// output slot is free when empty or its transfer completes this cycle
	assign out_free = !out_valid_q || !out_stall;

	hfw_ram #(.WIDTH(32), .ADDR_W(ADDR_W)) u_height_ram (
		.clk (clk),
		.we  (mem_req.h_we),
		.wa  (mem_req.h_wa),
		.wd  (mem_req.h_wd),
		.ra  (mem_req.h_ra),
		.rd  (h_rd)
	);

	hfw_ram #(.WIDTH(32), .ADDR_W(ADDR_W)) u_velocity_ram (
		.clk (clk),
		.we  (mem_req.v_we),
		.wa  (mem_req.v_wa),
		.wd  (mem_req.v_wd),
		.ra  (mem_req.v_ra),
		.rd  (v_rd)
	);

	hfw_engine u_engine (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.in_take      (in_take),
		.mode         (mode),
		.cell_x       (cell_x),
		.cell_z       (cell_z),
		.height_value (height_value),
		.time_step    (time_step),
		.out_free     (out_free),
		.h_rd         (h_rd),
		.v_rd         (v_rd),
		.mem_req      (mem_req),
		.busy         (busy),
		.res_valid    (res_valid),
		.res          (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) out_q <= res;
	end

	assign out_valid    = out_valid_q;
	assign result_kind  = out_q.result_kind;
	assign height_out   = out_q.height;
	assign velocity_out = out_q.velocity;
	assign saturated    = out_q.saturated;

endmodule

// ===== design/hfw_ram.sv =====
// ----------------------------------------------------------------------------
// hfw_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module hfw_ram #(
	parameter int WIDTH  = 32,
	parameter int ADDR_W = 12
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] wa,
	input  logic [WIDTH-1:0]  wd,
	input  logic [ADDR_W-1:0] ra,
	output logic [WIDTH-1:0]  rd
);

	logic [WIDTH-1:0] mem [1 << ADDR_W];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd <= mem[ra];
	end

endmodule

// ===== design/hfw_engine.sv =====
// ----------------------------------------------------------------------------
// hfw_engine
// Sequencer and datapath: loads, reads, coefficient setup and the two passes.
// ----------------------------------------------------------------------------
module hfw_engine (
	input  logic               clk,
	input  logic               arst_n,
	input  hfw_pkg::cfg_t      cfg,
	input  logic               in_take,
	input  logic [1:0]         mode,
	input  logic [5:0]         cell_x,
	input  logic [5:0]         cell_z,
	input  logic signed [31:0] height_value,
	input  logic [15:0]        time_step,
	input  logic               out_free,
	input  logic [31:0]        h_rd,
	input  logic [31:0]        v_rd,
	output hfw_pkg::mem_req_t  mem_req,
	output logic               busy,
	output logic               res_valid,
	output hfw_pkg::result_t   res
);
	import hfw_pkg::*;

	state_t state_q, state_d;
	logic [3:0] ph_q;
	logic [GRID_X_BITS-1:0] x_q, last_x;
	logic [GRID_Z_BITS-1:0] z_q, last_z;
	logic [COL_W-1:0] nx_c, nz_c;
	logic flag_q;

	logic [15:0] dt_q;
	logic [27:0] gd_q;
	logic [30:0] c2_q, coef_q;
	logic [31:0] coef2_q;
	logic signed [31:0] hc_q, vc_q, lap_q, vs_q;
	logic signed [35:0] acc_q;
	logic [63:0] prod_q;
	logic signed [49:0] dp_q;
	result_t res_q;

	logic [ADDR_W-1:0] a, addr_l, addr_r, addr_u, addr_d;
	logic last_cell, row_end;
	logic [2:0] lvl;
	logic [35:0] gd_full;
	logic [46:0] c2_full, coef_full;
	logic [62:0] coef2_full;
	logic signed [35:0] lap_sum;
	logic signed [63:0] lap_ext, vsum, h_sum;
	logic [31:0] mag;
	logic [63:0] pm;
	logic signed [49:0] dp_c, dh_c;
	logic [31:0] v_new, h_new;

	always_comb begin
		nx_c = (cfg.active_columns_x == '0) ? COL_W'(1) :
			(cfg.active_columns_x > 7'(GRID_X)) ? COL_W'(GRID_X) : COL_W'(cfg.active_columns_x);
		nz_c = (cfg.active_columns_z == '0) ? COL_W'(1) :
			(cfg.active_columns_z > 7'(GRID_Z)) ? COL_W'(GRID_Z) : COL_W'(cfg.active_columns_z);
		last_x = GRID_X_BITS'(nx_c - COL_W'(1));
		last_z = GRID_Z_BITS'(nz_c - COL_W'(1));
		row_end = (x_q == last_x);
		last_cell = row_end && (z_q == last_z);

		a = {z_q, x_q};
		// edge cells mirror themselves: read the center again
		addr_l = (x_q != '0) ? {z_q, x_q - 1'b1} : a;
		addr_r = (x_q != last_x) ? {z_q, x_q + 1'b1} : a;
		addr_u = (z_q != '0) ? {z_q - 1'b1, x_q} : a;
		addr_d = (z_q != last_z) ? {z_q + 1'b1, x_q} : a;

		lvl = (cfg.speed_level > 3'd4) ? 3'd4 : cfg.speed_level;
		gd_full = 36'(cfg.water_depth) * 36'(GRAVITY_Q16) + 36'd128;
		c2_full = 47'(gd_q) * 47'(speed_factor(lvl)) + 47'd32768;
		coef_full = 47'(dt_q) * 47'(c2_q) + 47'd32768;
		coef2_full = 63'(coef_q) * 63'(cfg.inverse_cell_area) + 63'd32768;

		lap_sum = acc_q + 36'(signed'(h_rd)) - (36'(hc_q) <<< 2);
		lap_ext = 64'(lap_sum);

		mag = lap_q[31] ? (32'd0 - $unsigned(lap_q)) : $unsigned(lap_q);
		pm = (prod_q + 64'd32768) >> 16;
		vsum = 64'(vc_q) + (lap_q[31] ? $signed(64'd0 - pm) : $signed(pm));

		dp_c = vs_q * $signed({1'b0, DAMP_Q16});
		v_new = 32'(rnd16(64'(dp_q)));

		dh_c = signed'(v_rd) * $signed({1'b0, dt_q});
		h_sum = 64'(hc_q) + rnd16(64'(dp_q));
		h_new = sat32(h_sum);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_take) begin
					case (mode)
						MODE_STEP: state_d = ST_COEF;
						MODE_READ: state_d = ST_READ;
						default:   state_d = ST_IDLE;
					endcase
				end
			end
			ST_READ: state_d = ST_DONE;
			ST_COEF: if (ph_q == 4'd3) state_d = ST_VEL;
			ST_VEL:  if (ph_q == 4'd9 && last_cell) state_d = ST_HGT;
			ST_HGT:  if (ph_q == 4'd2 && last_cell) state_d = ST_DONE;
			ST_DONE: if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// memory requests and handshake outputs
	always_comb begin
		mem_req = '0;
		res_valid = 1'b0;
		busy = (state_q != ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				mem_req.h_ra = {cell_z, cell_x};
				mem_req.v_ra = {cell_z, cell_x};
				mem_req.h_wa = {cell_z, cell_x};
				mem_req.v_wa = {cell_z, cell_x};
				mem_req.h_wd = height_value;
				if (in_take && mode == MODE_LOAD) begin
					mem_req.h_we = 1'b1;
					mem_req.v_we = 1'b1;
				end
			end
			ST_VEL: begin
				mem_req.v_ra = a;
				mem_req.v_wa = a;
				mem_req.v_wd = v_new;
				case (ph_q)
					4'd0:    mem_req.h_ra = a;
					4'd1:    mem_req.h_ra = addr_l;
					4'd2:    mem_req.h_ra = addr_r;
					4'd3:    mem_req.h_ra = addr_u;
					4'd4:    mem_req.h_ra = addr_d;
					4'd9:    mem_req.v_we = 1'b1;
					default: mem_req.h_ra = a;
				endcase
			end
			ST_HGT: begin
				mem_req.h_ra = a;
				mem_req.v_ra = a;
				mem_req.h_wa = a;
				mem_req.h_wd = h_new;
				mem_req.h_we = (ph_q == 4'd2);
			end
			ST_DONE: res_valid = out_free;
			default: ;
		endcase
	end

	assign res = res_q;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ph_q <= '0;
			x_q <= '0;
			z_q <= '0;
			flag_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					ph_q <= '0;
					x_q <= '0;
					z_q <= '0;
					if (in_take && mode == MODE_STEP) flag_q <= 1'b0;
				end
				ST_COEF: begin
					ph_q <= (ph_q == 4'd3) ? 4'd0 : ph_q + 4'd1;
					if (ph_q == 4'd3 && (|coef2_full[62:48])) flag_q <= 1'b1;
				end
				ST_VEL, ST_HGT: begin
					if ((state_q == ST_VEL && ph_q == 4'd9) ||
						(state_q == ST_HGT && ph_q == 4'd2)) begin
						ph_q <= '0;
						if (row_end) begin
							x_q <= '0;
							z_q <= last_cell ? '0 : z_q + 1'b1;
						end else begin
							x_q <= x_q + 1'b1;
						end
					end else begin
						ph_q <= ph_q + 4'd1;
					end
					if (state_q == ST_VEL && ph_q == 4'd5 && ovf32(lap_ext)) flag_q <= 1'b1;
					if (state_q == ST_VEL && ph_q == 4'd7 && ovf32(vsum)) flag_q <= 1'b1;
					if (state_q == ST_HGT && ph_q == 4'd2 && ovf32(h_sum)) flag_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: if (in_take) dt_q <= time_step;
			ST_READ: res_q <= '{result_kind: KIND_READ, height: h_rd, velocity: v_rd,
				saturated: 1'b0};
			ST_COEF: begin
				case (ph_q)
					4'd0:    gd_q <= gd_full[35:8];
					4'd1:    c2_q <= c2_full[46:16];
					4'd2:    coef_q <= coef_full[46:16];
					default: coef2_q <= (|coef2_full[62:48]) ? 32'hFFFF_FFFF : coef2_full[47:16];
				endcase
			end
			ST_VEL: begin
				case (ph_q)
					4'd1: begin
						hc_q <= h_rd;
						vc_q <= v_rd;
					end
					4'd2:    acc_q <= 36'(signed'(h_rd));
					4'd3:    acc_q <= acc_q + 36'(signed'(h_rd));
					4'd4:    acc_q <= acc_q + 36'(signed'(h_rd));
					4'd5:    lap_q <= sat32(lap_ext);
					4'd6:    prod_q <= {32'd0, mag} * {32'd0, coef2_q};
					4'd7:    vs_q <= sat32(vsum);
					4'd8:    dp_q <= dp_c;
					default: ;
				endcase
			end
			ST_HGT: begin
				if (ph_q == 4'd1) begin
					hc_q <= h_rd;
					dp_q <= dh_c;
				end
				if (ph_q == 4'd2 && last_cell) begin
					res_q <= '{result_kind: KIND_STEP, height: 32'd0, velocity: 32'd0,
						saturated: flag_q | ovf32(h_sum)};
				end
			end
			default: ;
		endcase
	end

endmodule

// ===== sim/height_field_wave_step_tb.sv =====
// ----------------------------------------------------------------------------
// height_field_wave_step_tb
// Self-checking bench for the height-field wave stepper: a directed table,
// then phases of random loads, reads and time steps under several register
// settings. Read and step results are checked against the table value where
// a row gives one, else against an in-bench fixed-point model of the grid.
// ----------------------------------------------------------------------------
module height_field_wave_step_tb;
	import hfw_pkg::*;

	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam int         WDOG_LIMIT  = 200000;
	localparam int         N_DIR       = 15;

	typedef struct {
		logic        kind;
		logic [31:0] hgt;
		logic [31:0] vel;
		logic        sat;
	} wave_result_t;

	typedef struct {
		logic [1:0]   mode;
		logic [5:0]   x;
		logic [5:0]   z;
		logic [31:0]  hv;
		logic [15:0]  dt;
		bit           typed;
		wave_result_t res;
	} dir_row_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [2:0]         cfg_index = '0;
	logic [31:0]        cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [1:0]         mode = '0;
	logic [5:0]         cell_x = '0;
	logic [5:0]         cell_z = '0;
	logic signed [31:0] height_value = '0;
	logic [15:0]        time_step = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic               result_kind;
	logic signed [31:0] height_out;
	logic signed [31:0] velocity_out;
	logic               saturated;

	always #1 clk = ~clk;

	height_field_wave_step uut (
		.clk, .arst_n,
		.cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
		.in_valid, .in_stall, .mode, .cell_x, .cell_z, .height_value, .time_step,
		.out_valid, .out_stall, .result_kind, .height_out, .velocity_out, .saturated
	);

	// ---------------------------------------------------------------------
	// Grid model: register copy plus height and velocity per cell
	// ---------------------------------------------------------------------
	logic [15:0]        m_depth;
	logic [2:0]         m_level;
	logic [31:0]        m_inv_area;
	logic [6:0]         m_cols_x;
	logic [6:0]         m_cols_z;
	logic signed [31:0] m_hgt [DEPTH];
	logic signed [31:0] m_vel [DEPTH];

	// cells loaded so far; reads and steps only ever touch these
	bit                 loaded [DEPTH];
	int                 loaded_list [$];

	wave_result_t       expected_results [$];
	int                 err_count = 0;
	int                 results_seen = 0;

	function automatic int clamp_cols(logic [6:0] n);
		if (n < 1) return 1;
		if (n > 64) return 64;
		return int'(n);
	endfunction

	// right shift by 16, half away from zero
	function automatic longint shr16_round(longint v);
		longint unsigned m;
		m = (v < 0) ? longint'(-v) : longint'(v);
		m = (m + 64'd32768) >> 16;
		return (v < 0) ? -longint'(m) : longint'(m);
	endfunction

	function automatic logic signed [31:0] clip32(longint v, ref bit flag);
		if (v > 64'sd2147483647) begin
			flag = 1;
			return 32'sh7FFF_FFFF;
		end
		if (v < -64'sd2147483648) begin
			flag = 1;
			return 32'sh8000_0000;
		end
		return v[31:0];
	endfunction

	// One time step over the active region; returns the saturation flag.
	function automatic bit wave_advance(logic [15:0] dt);
		bit                flag;
		int                nx, nz, a;
		longint unsigned   fac, gd, c2, coef, coef2, mag, pm;
		longint            h, l, r, u, d, dv, v;
		logic signed [31:0] lap, vs;
		flag = 0;
		nx = clamp_cols(m_cols_x);
		nz = clamp_cols(m_cols_z);
		case (m_level)
			3'd0:    fac = 262144;
			3'd1:    fac = 131072;
			3'd2:    fac = 65536;
			3'd3:    fac = 52429;
			default: fac = 32768;
		endcase
		gd    = (longint'(m_depth) * 642253 + 128) >> 8;
		c2    = (gd * fac + 32768) >> 16;
		coef  = (longint'(dt) * c2 + 32768) >> 16;
		coef2 = (coef * longint'(m_inv_area) + 32768) >> 16;
		if (coef2 > 64'hFFFF_FFFF) begin
			coef2 = 64'hFFFF_FFFF;
			flag = 1;
		end
		for (int z = 0; z < nz; z++)
			for (int x = 0; x < nx; x++) begin
				a = z * GRID_X + x;
				h = m_hgt[a];
				// edge cells mirror themselves
				l = (x > 0) ? m_hgt[a - 1] : h;
				r = (x + 1 < nx) ? m_hgt[a + 1] : h;
				u = (z > 0) ? m_hgt[a - GRID_X] : h;
				d = (z + 1 < nz) ? m_hgt[a + GRID_X] : h;
				lap = clip32(l + r + u + d - 4 * h, flag);
				mag = (lap < 0) ? longint'(-longint'(lap)) : longint'(lap);
				pm = (mag * coef2 + 32768) >> 16;
				dv = (lap < 0) ? -longint'(pm) : longint'(pm);
				vs = clip32(longint'(m_vel[a]) + dv, flag);
				v = shr16_round(longint'(vs) * 65470);
				m_vel[a] = v[31:0];
			end
		// heights only move once every velocity is new
		for (int z = 0; z < nz; z++)
			for (int x = 0; x < nx; x++) begin
				a = z * GRID_X + x;
				v = shr16_round(longint'(m_vel[a]) * longint'(dt));
				m_hgt[a] = clip32(longint'(m_hgt[a]) + v, flag);
			end
		return flag;
	endfunction

	// Applies one accepted transfer to the model; has_res tells if a result follows.
	function automatic void grid_apply(logic [1:0] md, logic [5:0] x, logic [5:0] z,
			logic [31:0] hv, logic [15:0] dt, output bit has_res, output wave_result_t res);
		int a;
		a = int'(z) * GRID_X + int'(x);
		has_res = 0;
		res = '{KIND_READ, 32'd0, 32'd0, 1'b0};
		case (md)
			MODE_LOAD: begin
				m_hgt[a] = hv;
				m_vel[a] = '0;
				if (!loaded[a]) begin
					loaded[a] = 1;
					loaded_list = {loaded_list, a};
				end
			end
			MODE_STEP: begin
				has_res = 1;
				res.kind = KIND_STEP;
				res.sat = wave_advance(dt);
			end
			MODE_READ: begin
				has_res = 1;
				res.hgt = m_hgt[a];
				res.vel = m_vel[a];
			end
			default: ;
		endcase
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
		err_count++;
	endtask

	// ---------------------------------------------------------------------
	// Result side: random stall, one forced long hold, in-order check
	// ---------------------------------------------------------------------
	int  hold_cnt = 0;
	bit  calm = 0;

	always @(posedge clk) begin
		wave_result_t w;
		int r;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				results_seen++;
				if (expected_results.size() == 0) begin
					$display("unexpected result transfer at %0t", $time);
					err_count++;
				end else begin
					w = expected_results.pop_front();
					if (result_kind !== w.kind)
						report_mismatch("result_kind", 32'(result_kind), 32'(w.kind));
					if (height_out !== w.hgt) report_mismatch("height_out", height_out, w.hgt);
					if (velocity_out !== w.vel) report_mismatch("velocity_out", velocity_out, w.vel);
					if (saturated !== w.sat)
						report_mismatch("saturated", 32'(saturated), 32'(w.sat));
				end
				// long hold while the sender keeps offering: fills the block
				if (results_seen == 5) hold_cnt = 400;
			end
			if ($urandom_range(0, 255) == 0) calm = ~calm;
			r = $urandom_range(0, 99);
			if (hold_cnt > 0) begin
				hold_cnt--;
				out_stall <= 1'b1;
			end else if (calm) begin
				out_stall <= 1'b0;
			end else if (r < 2) begin
				hold_cnt = $urandom_range(30, 200);
				out_stall <= 1'b1;
			end else begin
				out_stall <= (r < 27);
			end
		end
	end

	// ---------------------------------------------------------------------
	// Watchdog: cycles with no transfer on any channel
	// ---------------------------------------------------------------------
	int quiet_cycles = 0;

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WDOG_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// ---------------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------------
	task automatic reg_write(logic [2:0] idx, logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			CFG_WATER_DEPTH: m_depth = val[15:0];
			CFG_SPEED_LEVEL: m_level = val[2:0];
			CFG_INV_AREA:    m_inv_area = val;
			CFG_ACTIVE_X:    m_cols_x = val[6:0];
			CFG_ACTIVE_Z:    m_cols_z = val[6:0];
			default: ;
		endcase
	endtask

	// Sender goes quiet; block goes idle once results are drained.
	task automatic drain();
		in_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic configure(logic [15:0] depth, logic [2:0] lvl, logic [31:0] inv,
			logic [6:0] ax, logic [6:0] az);
		drain();
		reg_write(CFG_WATER_DEPTH, 32'(depth));
		reg_write(CFG_SPEED_LEVEL, 32'(lvl));
		reg_write(CFG_INV_AREA, inv);
		reg_write(CFG_ACTIVE_X, 32'(ax));
		reg_write(CFG_ACTIVE_Z, 32'(az));
		cfg_valid <= 1'b0;
	endtask

	// Offers one transfer after a random gap, waits for it, then predicts.
	task automatic offer(logic [1:0] md, logic [5:0] x, logic [5:0] z,
			logic [31:0] hv, logic [15:0] dt, bit typed, wave_result_t want);
		int           r, gap;
		bit           has_res;
		wave_result_t res;
		r = $urandom_range(0, 99);
		gap = (r < 60) ? 0 : (r < 92) ? $urandom_range(1, 3) : $urandom_range(10, 40);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= md;
		cell_x <= x;
		cell_z <= z;
		height_value <= hv;
		time_step <= dt;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		grid_apply(md, x, z, hv, dt, has_res, res);
		if (has_res) expected_results = {expected_results, typed ? want : res};
	endtask

	function automatic logic [31:0] pick_height();
		if ($urandom_range(0, 5) == 0) return $urandom;
		return $urandom_range(0, 1 << 21) - (1 << 20);
	endfunction

	wave_result_t no_res = '{KIND_READ, 32'd0, 32'd0, 1'b0};

	task automatic plain(logic [1:0] md, logic [5:0] x, logic [5:0] z,
			logic [31:0] hv, logic [15:0] dt);
		offer(md, x, z, hv, dt, 0, no_res);
	endtask

	// Loads every not yet loaded cell of the active region.
	task automatic fill_active();
		int nx, nz;
		nx = clamp_cols(m_cols_x);
		nz = clamp_cols(m_cols_z);
		for (int z = 0; z < nz; z++)
			for (int x = 0; x < nx; x++)
				if (!loaded[z * GRID_X + x])
					plain(MODE_LOAD, 6'(x), 6'(z), pick_height(), 16'($urandom));
	endtask

	// Mixed traffic: mostly reads, loads and steps, a little noise.
	task automatic random_traffic(int n);
		int r, a;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			a = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
			if (r < 8)
				plain(MODE_UNUSED, 6'($urandom), 6'($urandom), $urandom, 16'($urandom));
			else if (r < 45)
				plain(MODE_READ, 6'(a % GRID_X), 6'(a / GRID_X), $urandom, 16'($urandom));
			else if (r < 70)
				plain(MODE_LOAD, 6'($urandom), 6'($urandom), pick_height(), 16'($urandom));
			else if (r < 92)
				plain(MODE_STEP, 6'($urandom), 6'($urandom), $urandom, 16'($urandom));
			else
				drain();    // sender pauses until everything is back
		end
	endtask

	dir_row_t dir_tab [N_DIR];

	initial begin
		// reset values of the registers
		m_depth = 16'd256;
		m_level = 3'd2;
		m_inv_area = 32'd65536;
		m_cols_x = 7'd64;
		m_cols_z = 7'd64;
		foreach (m_hgt[i]) begin
			m_hgt[i] = '0;
			m_vel[i] = '0;
		end

		// Directed table, 2 x 2 region, top depth, speed and inverse area:
		// corner extremes, unused mode, a read outside the active region,
		// a step whose coefficient saturates and a zero-length step.
		dir_tab[0]  = '{MODE_LOAD, 0, 0, 32'h7FFF_FFFF, 0, 0, no_res};
		dir_tab[1]  = '{MODE_LOAD, 1, 0, 32'h8000_0000, 0, 0, no_res};
		dir_tab[2]  = '{MODE_LOAD, 0, 1, 32'h0000_0000, 0, 0, no_res};
		dir_tab[3]  = '{MODE_LOAD, 1, 1, 32'hFFFF_FFFF, 0, 0, no_res};
		dir_tab[4]  = '{MODE_LOAD, 63, 63, 32'h007B_0000, 0, 0, no_res};
		dir_tab[5]  = '{MODE_UNUSED, 63, 63, 32'hFFFF_FFFF, 16'hFFFF, 0, no_res};
		dir_tab[6]  = '{MODE_READ, 0, 0, 0, 0, 1, '{KIND_READ, 32'h7FFF_FFFF, 0, 0}};
		dir_tab[7]  = '{MODE_READ, 1, 0, 0, 0, 1, '{KIND_READ, 32'h8000_0000, 0, 0}};
		dir_tab[8]  = '{MODE_READ, 63, 63, 0, 0, 1, '{KIND_READ, 32'h007B_0000, 0, 0}};
		dir_tab[9]  = '{MODE_STEP, 0, 0, 0, 16'hFFFF, 1, '{KIND_STEP, 0, 0, 1}};
		dir_tab[10] = '{MODE_READ, 1, 1, 0, 0, 0, no_res};
		dir_tab[11] = '{MODE_STEP, 0, 0, 0, 16'h0000, 0, no_res};
		dir_tab[12] = '{MODE_READ, 0, 1, 0, 0, 0, no_res};
		dir_tab[13] = '{MODE_READ, 63, 63, 0, 0, 1, '{KIND_READ, 32'h007B_0000, 0, 0}};
		dir_tab[14] = '{MODE_STEP, 63, 63, 32'h1234_5678, 16'h0001, 0, no_res};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		configure(16'hFFFF, 3'd0, 32'hFFFF_FFFF, 7'd2, 7'd2);
		foreach (dir_tab[i])
			offer(dir_tab[i].mode, dir_tab[i].x, dir_tab[i].z, dir_tab[i].hv,
				dir_tab[i].dt, dir_tab[i].typed, dir_tab[i].res);

		// Random phases; zero sizes clamp, level seven acts as four.
		configure(16'd0, 3'd4, 32'd0, 7'd1, 7'd1);
		fill_active();
		random_traffic(15);
		configure(16'd256, 3'd7, 32'd65536, 7'd0, 7'd5);
		fill_active();
		random_traffic(15);
		configure(16'd1000, 3'd3, 32'd30000, 7'd5, 7'd4);
		fill_active();
		random_traffic(15);
		configure(16'd300, 3'd1, 32'd100000, 7'd4, 7'd4);
		fill_active();
		random_traffic(15);
		configure(16'd77, 3'd2, 32'd8000, 7'd3, 7'd6);
		fill_active();
		random_traffic(15);

		drain();
		repeat (20) @(posedge clk);
		if (expected_results.size() != 0) begin
			$display("%0d expected results never arrived", expected_results.size());
			err_count++;
		end
		if (err_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== sim.f =====
design/hfw_pkg.sv
design/hfw_ram.sv
design/hfw_engine.sv
design/height_field_wave_step.sv
sim/height_field_wave_step_tb.sv
